FILE: design/sfcc_pkg.sv
// Shared types and constants for the contour colour map pipeline.
package sfcc_pkg;

  // Default geometry of the sample words and of the contour phase table.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF  = 10;

  // Pipeline depth, counted in register stages.
  localparam int NUM_STAGES = 7;

  // Configuration write port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;

  // Q16 arithmetic constants.
  localparam int Q16_ONE      = 65536;
  localparam int Q16_HALF     = 32768;
  localparam int C_BASE_GLOW  = 7864;
  localparam int C_LEVEL_GAIN = 42598;
  localparam int C_SLOPE_GAIN = 327680;
  localparam int C_RED_MIX    = 29491;
  localparam int C_GREEN_MIX  = 42598;
  localparam int C_BLUE_MIX   = 52429;
  localparam int C_WARM_MIX   = 6554;

  // Register ranges and reset values.
  localparam int UNIT_MAX  = 256;
  localparam int RAD_MIN   = 26;
  localparam int RAD_MAX   = 768;
  localparam int DENS_MIN  = 512;
  localparam int DENS_MAX  = 6144;

  localparam logic [8:0]  RST_TINT_RED     = 9'd128;
  localparam logic [8:0]  RST_TINT_GREEN   = 9'd128;
  localparam logic [8:0]  RST_TINT_BLUE    = 9'd256;
  localparam logic [9:0]  RST_RADIANCE     = 10'd256;
  localparam logic [12:0] RST_DENSITY      = 13'd3072;
  localparam logic [8:0]  RST_STRENGTH     = 9'd141;
  localparam logic [8:0]  RST_OPACITY      = 9'd256;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TINT_RED         = 3'd0,
    REG_TINT_GREEN       = 3'd1,
    REG_TINT_BLUE        = 3'd2,
    REG_RADIANCE_GAIN    = 3'd3,
    REG_CONTOUR_DENSITY  = 3'd4,
    REG_CONTOUR_STRENGTH = 3'd5,
    REG_LAYER_OPACITY    = 3'd6
  } cfg_reg_t;

  // Register values after clamping to their working ranges.
  typedef struct packed {
    logic [8:0]  tint_red;
    logic [8:0]  tint_green;
    logic [8:0]  tint_blue;
    logic [9:0]  radiance;
    logic [12:0] density;
    logic [8:0]  strength;
  } cfg_sat_t;

  // One load enable per pipeline stage.
  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

FILE: design/sfcc_if.sv
// Handshake interfaces for the sample, colour and configuration words.
interface sfcc_in_if import sfcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corner_here;
  logic signed [SAMPLE_BITS-1:0] corner_right;
  logic signed [SAMPLE_BITS-1:0] corner_below;
  logic signed [SAMPLE_BITS-1:0] corner_diagonal;

  modport source (output valid, output corner_here, output corner_right,
                  output corner_below, output corner_diagonal, input ready);
  modport sink   (input valid, input corner_here, input corner_right,
                  input corner_below, input corner_diagonal, output ready);
endinterface

interface sfcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out,
                  output blue_out, output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out,
                  input blue_out, input alpha_out, output ready);
endinterface

interface sfcc_cfg_if import sfcc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/sfcc_geom.sv
// Front stages: level sum, slope, level and slope gains, phase index and warm term.
module sfcc_geom import sfcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic signed [SAMPLE_BITS-1:0] corner_here,
  input  logic signed [SAMPLE_BITS-1:0] corner_right,
  input  logic signed [SAMPLE_BITS-1:0] corner_below,
  input  logic signed [SAMPLE_BITS-1:0] corner_diagonal,
  input  logic [12:0]                   density,
  output logic [21:0]                   lvl_r,
  output logic [24:0]                   slp_r,
  output logic [PHASE_BITS-1:0]         idx_r,
  output logic [16:0]                   warm_r
);

  localparam int F       = SAMPLE_BITS - 4;
  localparam int SW      = SAMPLE_BITS + 2;
  localparam int IDX_LSB = SAMPLE_BITS + 6 - PHASE_BITS;

  // Stage one: corner sum, its magnitude and the slope.
  logic signed [SW-1:0]        sum_r, sum_nxt;
  logic [SW-1:0]               asum_r, asum_nxt;
  logic [SW-1:0]               slope_r, slope_nxt;
  logic signed [SAMPLE_BITS:0] d_right, d_below;
  logic [SAMPLE_BITS:0]        a_right, a_below;

  always_comb begin
    sum_nxt  = SW'(corner_here) + SW'(corner_right) + SW'(corner_below)
             + SW'(corner_diagonal);
    asum_nxt = sum_nxt[SW-1] ? SW'(-sum_nxt) : SW'(sum_nxt);
    d_right  = (SAMPLE_BITS+1)'(corner_right) - (SAMPLE_BITS+1)'(corner_here);
    d_below  = (SAMPLE_BITS+1)'(corner_below) - (SAMPLE_BITS+1)'(corner_here);
    a_right  = d_right[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_right)
                                    : (SAMPLE_BITS+1)'(d_right);
    a_below  = d_below[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_below)
                                    : (SAMPLE_BITS+1)'(d_below);
    slope_nxt = SW'(a_right) + SW'(a_below);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_r   <= sum_nxt;
      asum_r  <= asum_nxt;
      slope_r <= slope_nxt;
    end
  end

  // Stage two: gain products, phase product and the warm term.
  logic [SAMPLE_BITS+17:0]        lvl_prod;
  logic [SAMPLE_BITS+20:0]        slp_prod;
  logic signed [SAMPLE_BITS+15:0] phase_prod;
  logic [SAMPLE_BITS+16:0]        lift_w;
  logic [20:0]                    lift;
  logic [21:0]                    warm_hi;
  logic [16:0]                    warm_nxt;

  always_comb begin
    lvl_prod   = (SAMPLE_BITS+18)'(asum_r) * (SAMPLE_BITS+18)'(C_LEVEL_GAIN);
    slp_prod   = (SAMPLE_BITS+21)'(slope_r) * (SAMPLE_BITS+21)'(C_SLOPE_GAIN);
    phase_prod = (SAMPLE_BITS+16)'(sum_r)
               * (SAMPLE_BITS+16)'($signed({1'b0, density}));
    lift_w     = {asum_r, 15'b0};
    lift       = lift_w[SAMPLE_BITS+16:F];
    warm_hi    = 22'(lift) + 22'(Q16_HALF);
    if (!sum_r[SW-1]) begin
      warm_nxt = (warm_hi > 22'(Q16_ONE)) ? 17'(Q16_ONE) : warm_hi[16:0];
    end else begin
      warm_nxt = (lift >= 21'(Q16_HALF)) ? 17'd0 : 17'(21'(Q16_HALF) - lift);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lvl_r  <= lvl_prod[SAMPLE_BITS+17:F];
      slp_r  <= slp_prod[SAMPLE_BITS+20:F];
      idx_r  <= phase_prod[IDX_LSB +: PHASE_BITS];
      warm_r <= warm_nxt;
    end
  end

endmodule

FILE: design/sfcc_contour.sv
// Contour table with registered read and scaling by the contour strength.
module sfcc_contour import sfcc_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  stage_en_t             en,
  input  logic [PHASE_BITS-1:0] idx,
  input  logic [8:0]            strength,
  output logic [16:0]           contour_r
);

  localparam int ROM_SIZE = 1 << PHASE_BITS;
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

  // cos^22 of the phase in Q16, zero outside the positive half of the cosine.
  function automatic logic [16:0] rom_entry(input int unsigned k);
    logic [63:0] size, d, x, x2, t, q, c2, c4, c8, c16, p;
    size = 64'd1 << PHASE_BITS;
    d    = (64'(k) <= (size >> 1)) ? 64'(k) : size - 64'(k);
    if (d >= (size >> 2)) begin
      return 17'd0;
    end
    x  = (d * TWO_PI_Q28) >> (PHASE_BITS - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    q  = ((x2 * t) >> 30) / 64'd132;
    t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    q  = ((x2 * t) >> 30) / 64'd90;
    t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    q  = ((x2 * t) >> 30) / 64'd56;
    t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    q  = ((x2 * t) >> 30) / 64'd30;
    t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    q  = ((x2 * t) >> 30) / 64'd12;
    t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    q  = ((x2 * t) >> 30) / 64'd2;
    t  = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    c2  = (t * t) >> 30;
    c4  = (c2 * c2) >> 30;
    c8  = (c4 * c4) >> 30;
    c16 = (c8 * c8) >> 30;
    p   = (c16 * c4) >> 30;
    p   = (p * c2) >> 30;
    return p[30:14];
  endfunction

  logic [16:0] rom_tbl [ROM_SIZE];

  for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
    assign rom_tbl[k] = rom_entry(k);
  end

  logic [16:0] rom_q_r;
  logic [25:0] scaled;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rom_q_r <= rom_tbl[idx];
    end
  end

  assign scaled = 26'(rom_q_r) * 26'(strength);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      contour_r <= scaled[24:8];
    end
  end

endmodule

FILE: design/sfcc_colour.sv
// Back stages: glow, channel mixing and conversion to 8-bit colour.
module sfcc_colour import sfcc_pkg::*; (
  input  logic        clk,
  input  stage_en_t   en,
  input  cfg_sat_t    cfg,
  input  logic [21:0] lvl,
  input  logic [24:0] slp,
  input  logic [16:0] warm,
  input  logic [16:0] contour,
  output logic [7:0]  red_r,
  output logic [7:0]  green_r,
  output logic [7:0]  blue_r
);

  // Saturate a Q16 value to one and round it to 8 bits.
  function automatic logic [7:0] to8(input logic [18:0] q);
    logic [16:0] qs;
    logic [24:0] p;
    qs = (q > 19'(Q16_ONE)) ? 17'(Q16_ONE) : q[16:0];
    p  = 25'(qs) * 25'd255 + 25'(Q16_HALF);
    return p[23:16];
  endfunction

  // Stage three: unscaled glow.
  logic [25:0] pre_r;
  logic [16:0] warm3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pre_r   <= 26'(C_BASE_GLOW) + 26'(lvl) + 26'(slp);
      warm3_r <= warm;
    end
  end

  // Stage four: glow scaled by the radiance gain and clamped.
  logic [35:0] glow_prod;
  logic [16:0] glow_r, warm4_r;

  assign glow_prod = 36'(pre_r) * 36'(cfg.radiance);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      glow_r  <= (glow_prod[35:8] > 28'(Q16_ONE)) ? 17'(Q16_ONE) : glow_prod[24:8];
      warm4_r <= warm3_r;
    end
  end

  // Stage five: tinted glow, warm glow and contour mixing products.
  logic [25:0] tr_p, tg_p, tb_p;
  logic [33:0] wg_p;
  logic [32:0] cr_p, cg_p, cb_p;
  logic [16:0] tr_r, tg_r, tb_r, wg_r, cr_r, cg_r, cb_r;

  always_comb begin
    tr_p = 26'(cfg.tint_red)   * 26'(glow_r);
    tg_p = 26'(cfg.tint_green) * 26'(glow_r);
    tb_p = 26'(cfg.tint_blue)  * 26'(glow_r);
    wg_p = 34'(warm4_r) * 34'(glow_r);
    cr_p = 33'(contour) * 33'(C_RED_MIX);
    cg_p = 33'(contour) * 33'(C_GREEN_MIX);
    cb_p = 33'(contour) * 33'(C_BLUE_MIX);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tr_r <= tr_p[24:8];
      tg_r <= tg_p[24:8];
      tb_r <= tb_p[24:8];
      wg_r <= wg_p[32:16];
      cr_r <= cr_p[32:16];
      cg_r <= cg_p[32:16];
      cb_r <= cb_p[32:16];
    end
  end

  // Stage six: warm highlight on red and channel sums.
  logic [32:0] wm_p;
  logic [18:0] rsum_r, gsum_r, bsum_r;

  assign wm_p = 33'(wg_r) * 33'(C_WARM_MIX);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rsum_r <= 19'(tr_r) + 19'(cr_r) + 19'(wm_p[32:16]);
      gsum_r <= 19'(tg_r) + 19'(cg_r);
      bsum_r <= 19'(tb_r) + 19'(cb_r);
    end
  end

  // Stage seven: the output register.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      red_r   <= to8(rsum_r);
      green_r <= to8(gsum_r);
      blue_r  <= to8(bsum_r);
    end
  end

endmodule

FILE: design/scalar_field_contour_colormap.sv
// Contour colour map for one grid cell of a scalar wave field: top level.
// Throughput is one word per cycle while the output is taken; each stage
// holds its word under back-pressure and an empty stage fills even while a
// later one is stalled.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers; the contour table is constant and needs no fill.
module scalar_field_contour_colormap import sfcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  sfcc_in_if.sink       in_ch,
  sfcc_out_if.source    out_ch,
  sfcc_cfg_if.sink      cfg_ch
);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an index beyond the
  // register list is ignored. Data is truncated to the register's width.
  // ---------------------------------------------------------------------
  logic [8:0]  tint_red_r, tint_red_nxt;
  logic [8:0]  tint_green_r, tint_green_nxt;
  logic [8:0]  tint_blue_r, tint_blue_nxt;
  logic [9:0]  radiance_r, radiance_nxt;
  logic [12:0] density_r, density_nxt;
  logic [8:0]  strength_r, strength_nxt;
  logic [8:0]  opacity_r, opacity_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    tint_red_nxt   = tint_red_r;
    tint_green_nxt = tint_green_r;
    tint_blue_nxt  = tint_blue_r;
    radiance_nxt   = radiance_r;
    density_nxt    = density_r;
    strength_nxt   = strength_r;
    opacity_nxt    = opacity_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_TINT_RED:         tint_red_nxt   = cfg_ch.data[8:0];
        REG_TINT_GREEN:       tint_green_nxt = cfg_ch.data[8:0];
        REG_TINT_BLUE:        tint_blue_nxt  = cfg_ch.data[8:0];
        REG_RADIANCE_GAIN:    radiance_nxt   = cfg_ch.data[9:0];
        REG_CONTOUR_DENSITY:  density_nxt    = cfg_ch.data[12:0];
        REG_CONTOUR_STRENGTH: strength_nxt   = cfg_ch.data[8:0];
        REG_LAYER_OPACITY:    opacity_nxt    = cfg_ch.data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_red_r   <= RST_TINT_RED;
      tint_green_r <= RST_TINT_GREEN;
      tint_blue_r  <= RST_TINT_BLUE;
      radiance_r   <= RST_RADIANCE;
      density_r    <= RST_DENSITY;
      strength_r   <= RST_STRENGTH;
      opacity_r    <= RST_OPACITY;
    end else begin
      tint_red_r   <= tint_red_nxt;
      tint_green_r <= tint_green_nxt;
      tint_blue_r  <= tint_blue_nxt;
      radiance_r   <= radiance_nxt;
      density_r    <= density_nxt;
      strength_r   <= strength_nxt;
      opacity_r    <= opacity_nxt;
    end
  end

  // Registers are clamped to their working ranges where they are used, so
  // an out-of-range write behaves as the nearest legal value.
  cfg_sat_t    cfg;
  logic [8:0]  opacity;
  logic [16:0] alpha_w;

  always_comb begin
    cfg.tint_red   = (tint_red_r   > 9'(UNIT_MAX)) ? 9'(UNIT_MAX) : tint_red_r;
    cfg.tint_green = (tint_green_r > 9'(UNIT_MAX)) ? 9'(UNIT_MAX) : tint_green_r;
    cfg.tint_blue  = (tint_blue_r  > 9'(UNIT_MAX)) ? 9'(UNIT_MAX) : tint_blue_r;
    cfg.strength   = (strength_r   > 9'(UNIT_MAX)) ? 9'(UNIT_MAX) : strength_r;
    if (radiance_r < 10'(RAD_MIN)) begin
      cfg.radiance = 10'(RAD_MIN);
    end else if (radiance_r > 10'(RAD_MAX)) begin
      cfg.radiance = 10'(RAD_MAX);
    end else begin
      cfg.radiance = radiance_r;
    end
    if (density_r < 13'(DENS_MIN)) begin
      cfg.density = 13'(DENS_MIN);
    end else if (density_r > 13'(DENS_MAX)) begin
      cfg.density = 13'(DENS_MAX);
    end else begin
      cfg.density = density_r;
    end
    opacity = (opacity_r > 9'(UNIT_MAX)) ? 9'(UNIT_MAX) : opacity_r;
    // Opacity rounded from Q1.8 to an 8-bit alpha.
    alpha_w = 17'(opacity) * 17'd255 + 17'd128;
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Each stage carries a valid bit and loads when it is
  // empty or when the stage after it loads, so bubbles are squeezed out
  // while the output word waits to be taken.
  // ---------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  stage_en_t             en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = en[0];

  // ---------------------------------------------------------------------
  // Datapath. Stages one and two form the level, slope, phase index and
  // warm term; stages three and four read and scale the contour table and
  // form the glow; stages five to seven mix and convert the channels.
  // ---------------------------------------------------------------------
  logic [21:0]           lvl;
  logic [24:0]           slp;
  logic [PHASE_BITS-1:0] idx;
  logic [16:0]           warm;
  logic [16:0]           contour;
  logic [7:0]            red, green, blue;

  sfcc_geom #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_geom (
    .clk             (clk),
    .en              (en),
    .corner_here     (in_ch.corner_here),
    .corner_right    (in_ch.corner_right),
    .corner_below    (in_ch.corner_below),
    .corner_diagonal (in_ch.corner_diagonal),
    .density         (cfg.density),
    .lvl_r           (lvl),
    .slp_r           (slp),
    .idx_r           (idx),
    .warm_r          (warm)
  );

  sfcc_contour #(
    .PHASE_BITS (PHASE_BITS)
  ) u_contour (
    .clk       (clk),
    .en        (en),
    .idx       (idx),
    .strength  (cfg.strength),
    .contour_r (contour)
  );

  sfcc_colour u_colour (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .lvl     (lvl),
    .slp     (slp),
    .warm    (warm),
    .contour (contour),
    .red_r   (red),
    .green_r (green),
    .blue_r  (blue)
  );

  // The alpha is a function of the opacity register alone, which the user must
  // change only while the block is idle; the block itself does not enforce this.
  assign out_ch.valid     = vld_r[NUM_STAGES-1];
  assign out_ch.red_out   = red;
  assign out_ch.green_out = green;
  assign out_ch.blue_out  = blue;
  assign out_ch.alpha_out = alpha_w[15:8];

endmodule

FILE: bench/sfcc_checker.sv
// Checker for the contour colour map: predicts every colour word and compares it.
module sfcc_checker import sfcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sfcc_in_if   in_mon,
  sfcc_out_if  out_mon,
  sfcc_cfg_if  cfg_mon,
  output int   fail_count,
  output int   colours_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = SAMPLE_BITS_DEF - 4;
  localparam int PHASE_BITS  = PHASE_BITS_DEF;
  localparam int LUT_SIZE    = 1 << PHASE_BITS;
  localparam int PHASE_SHIFT = SAMPLE_BITS_DEF + 6 - PHASE_BITS;
  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } colour_t;

  longint unsigned taylor_div [6] = '{132, 90, 56, 30, 12, 2};
  logic [16:0]     contour_lut [LUT_SIZE];
  colour_t         expected_colours [$];

  logic [8:0]  tint_red, tint_green, tint_blue, strength, opacity;
  logic [9:0]  radiance;
  logic [12:0] density;

  int n_fail    = 0;
  int n_pending = 0;

  assign fail_count      = n_fail;
  assign colours_pending = n_pending;

  // Cosine of the phase step d, Q30, by a truncated Taylor series in Horner form.
  function automatic longint unsigned cos_q30(longint unsigned d);
    longint unsigned x, x2, t, q;
    int i;
    x  = (d * TWO_PI_Q28) >> (PHASE_BITS - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (i = 0; i < 6; i++) begin
      q = ((x2 * t) >> 30) / taylor_div[i];
      t = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
    end
    return t;
  endfunction

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned lo,
                                            longint unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [7:0] to_byte(longint unsigned q16);
    if (q16 > Q16_ONE) q16 = Q16_ONE;
    return 8'((q16 * 255 + 32768) >> 16);
  endfunction

  function automatic colour_t predict_colour(logic signed [15:0] here, right, below, diag);
    longint          sum, prod, d_right, d_below;
    longint unsigned asum, slope, tr, tg, tb, rad, dens, str, op;
    longint unsigned pre, glow, contour, lift, warm, red, green, blue;
    int unsigned     idx;
    colour_t         col;
    sum     = longint'(here) + longint'(right) + longint'(below) + longint'(diag);
    asum    = (sum < 0) ? -sum : sum;
    d_right = longint'(right) - longint'(here);
    d_below = longint'(below) - longint'(here);
    slope   = ((d_right < 0) ? -d_right : d_right) + ((d_below < 0) ? -d_below : d_below);

    tr   = clamp(tint_red, 0, UNIT_MAX);
    tg   = clamp(tint_green, 0, UNIT_MAX);
    tb   = clamp(tint_blue, 0, UNIT_MAX);
    rad  = clamp(radiance, RAD_MIN, RAD_MAX);
    dens = clamp(density, DENS_MIN, DENS_MAX);
    str  = clamp(strength, 0, UNIT_MAX);
    op   = clamp(opacity, 0, UNIT_MAX);

    pre  = C_BASE_GLOW + ((asum * C_LEVEL_GAIN) >> FRAC_BITS)
         + ((slope * C_SLOPE_GAIN) >> FRAC_BITS);
    glow = (pre * rad) >> 8;
    if (glow > Q16_ONE) glow = Q16_ONE;

    // The phase wraps, so only the low bits of the scaled level matter.
    prod    = sum * longint'(dens);
    idx     = int'((prod >>> PHASE_SHIFT) & (LUT_SIZE - 1));
    contour = (longint'(contour_lut[idx]) * str) >> 8;

    lift = (asum << 15) >> FRAC_BITS;
    if (sum >= 0) warm = Q16_HALF + lift;
    else          warm = (lift >= Q16_HALF) ? 64'd0 : Q16_HALF - lift;
    if (warm > Q16_ONE) warm = Q16_ONE;

    red   = ((tr * glow) >> 8) + ((contour * C_RED_MIX) >> 16)
          + ((((warm * glow) >> 16) * C_WARM_MIX) >> 16);
    green = ((tg * glow) >> 8) + ((contour * C_GREEN_MIX) >> 16);
    blue  = ((tb * glow) >> 8) + ((contour * C_BLUE_MIX) >> 16);

    col.red   = to_byte(red);
    col.green = to_byte(green);
    col.blue  = to_byte(blue);
    col.alpha = 8'((op * 255 + 128) >> 8);
    return col;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // The table holds cos^22 over the first quarter turn either side of zero phase.
  initial begin : build_lut
    longint unsigned d, c, c2, c4, c8, c16, p;
    int k;
    for (k = 0; k < LUT_SIZE; k++) begin
      d = (k <= LUT_SIZE / 2) ? k : LUT_SIZE - k;
      if (d >= LUT_SIZE / 4) begin
        contour_lut[k] = '0;
      end else begin
        c   = cos_q30(d);
        c2  = (c * c) >> 30;
        c4  = (c2 * c2) >> 30;
        c8  = (c4 * c4) >> 30;
        c16 = (c8 * c8) >> 30;
        p   = (c16 * c4) >> 30;
        p   = (p * c2) >> 30;
        contour_lut[k] = 17'(p >> 14);
      end
    end
  end

  always @(posedge clk) begin : watch
    colour_t want;
    if (!rst_n) begin
      tint_red   = RST_TINT_RED;
      tint_green = RST_TINT_GREEN;
      tint_blue  = RST_TINT_BLUE;
      radiance   = RST_RADIANCE;
      density    = RST_DENSITY;
      strength   = RST_STRENGTH;
      opacity    = RST_OPACITY;
      expected_colours.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_colours.push_back(predict_colour(in_mon.corner_here, in_mon.corner_right,
                                                  in_mon.corner_below,
                                                  in_mon.corner_diagonal));
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_TINT_RED:         tint_red   = cfg_mon.data[8:0];
          REG_TINT_GREEN:       tint_green = cfg_mon.data[8:0];
          REG_TINT_BLUE:        tint_blue  = cfg_mon.data[8:0];
          REG_RADIANCE_GAIN:    radiance   = cfg_mon.data[9:0];
          REG_CONTOUR_DENSITY:  density    = cfg_mon.data[12:0];
          REG_CONTOUR_STRENGTH: strength   = cfg_mon.data[8:0];
          REG_LAYER_OPACITY:    opacity    = cfg_mon.data[8:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_colours.size() == 0) begin
          $error("colour word arrived with none expected");
          n_fail++;
        end else begin
          want = expected_colours.pop_front();
          compare_field("red_out",   want.red,   out_mon.red_out);
          compare_field("green_out", want.green, out_mon.green_out);
          compare_field("blue_out",  want.blue,  out_mon.blue_out);
          compare_field("alpha_out", want.alpha, out_mon.alpha_out);
        end
      end
    end
    n_pending = expected_colours.size();
  end

endmodule

FILE: bench/scalar_field_contour_colormap_tb.sv
// Top of the contour colour map testbench: clock, reset, stimulus and verdict.
module scalar_field_contour_colormap_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfcc_pkg::*;

  // The index above the last register; writes to it must leave every setting alone.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

  localparam int RANDOM_CELLS    = 1650;
  localparam int PHASES          = 8;
  localparam int CELLS_PER_PHASE = RANDOM_CELLS / PHASES;
  localparam int IDLE_HEAVY      = 81;
  localparam int IDLE_LIGHT      = 16;

  // One grid cell as it is put on the sample channel.
  typedef struct packed {
    logic [15:0] here;
    logic [15:0] right;
    logic [15:0] below;
    logic [15:0] diag;
  } cell_t;

  logic clk;
  logic rst_n;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   fail_count;
  int   colours_pending;

  sfcc_in_if  in_bus ();
  sfcc_out_if out_bus ();
  sfcc_cfg_if cfg_bus ();

  scalar_field_contour_colormap u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // The checker sits beside the block, watching all three channels, and reports
  // how many mismatches it has seen and how many colour words are still owed.
  sfcc_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .cfg_mon         (cfg_bus),
    .fail_count      (fail_count),
    .colours_pending (colours_pending)
  );

  // Directed cells, run under the reset settings. They cover the extremes of
  // every corner, the steepest slope, a cell where only the diagonal corner
  // differs (it should move the level but not the slope), the points where the
  // warm term just reaches its limits, and levels that put the contour phase at
  // its peak, just inside the quarter turn, and just beyond it on either sign.
  cell_t directed_cells [17] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
    '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
    '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000},
    '{16'h7FFF, 16'h8000, 16'h8000, 16'h8000},
    '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF},
    '{16'h0000, 16'h0000, 16'h0000, 16'h8000},
    '{16'h0400, 16'h0400, 16'h0400, 16'h0400},
    '{16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00},
    '{16'h0001, 16'h0001, 16'h0001, 16'h0001},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h0100, 16'h0100, 16'h0100, 16'h0100},
    '{16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00},
    '{16'h0155, 16'h0155, 16'h0155, 16'h0155},
    '{16'h0055, 16'h0055, 16'h0055, 16'h0055},
    '{16'h0800, 16'h0A00, 16'h0600, 16'h0800},
    '{16'h1000, 16'h0000, 16'h2000, 16'hF000}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: ready is redrawn every cycle, held low for the chosen share.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Lower and upper edge of the working range of each register.
  function automatic logic [CFG_DATA_BITS-1:0] reg_limit(cfg_reg_t r, bit upper);
    case (r)
      REG_RADIANCE_GAIN:   return CFG_DATA_BITS'(upper ? RAD_MAX  : RAD_MIN);
      REG_CONTOUR_DENSITY: return CFG_DATA_BITS'(upper ? DENS_MAX : DENS_MIN);
      default:             return CFG_DATA_BITS'(upper ? UNIT_MAX : 0);
    endcase
  endfunction

  function automatic logic [15:0] extreme_sample();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Nearly half of the random cells are smooth patches of field: corners anywhere
  // in roughly -1..1 with small differences between them, so the contour phase
  // sweeps the whole table. The rest are unrelated corners over the full range
  // and mixtures of extreme samples.
  function automatic cell_t random_cell();
    cell_t quad;
    int    kind;
    int    base;
    kind = $urandom_range(99);
    if (kind < 35) begin
      quad = {$urandom(), $urandom()};
    end else if (kind < 80) begin
      base       = $urandom_range(8191) - 4096;
      quad.here  = 16'(base + $urandom_range(64) - 32);
      quad.right = 16'(base + $urandom_range(64) - 32);
      quad.below = 16'(base + $urandom_range(64) - 32);
      quad.diag  = 16'(base + $urandom_range(64) - 32);
    end else begin
      quad.here  = extreme_sample();
      quad.right = extreme_sample();
      quad.below = extreme_sample();
      quad.diag  = extreme_sample();
    end
    return quad;
  endfunction

  // Offers one sample word, after an idle gap drawn cycle by cycle, and returns
  // at the edge where it is taken. Valid stays high for a following word when
  // no gap is drawn.
  task automatic send_cell(cell_t quad);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.corner_here     <= quad.here;
    in_bus.corner_right    <= quad.right;
    in_bus.corner_below    <= quad.below;
    in_bus.corner_diagonal <= quad.diag;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Register writes are issued back to back; the caller drops valid afterwards.
  task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Stops offering words and waits until every colour word owed has come out,
  // then lets the pipeline run empty. The count is read on the falling edge,
  // well away from the edge where the checker updates it.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (colours_pending != 0);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  // Writes every register for one phase. Phase 1 puts each at the bottom of its
  // range (zero opacity among them), phase 2 at the top, phase 3 outside the
  // range, phase 4 sets every data bit, so the bits above each register's width
  // are dropped and what remains is over range; later phases are random, now
  // and then with a full-width random word. Each phase also writes the spare
  // index, which must have no effect.
  task automatic load_settings(int phase);
    cfg_reg_t                 r;
    logic [CFG_DATA_BITS-1:0] value;
    cfg_write(REG_SPARE, CFG_DATA_BITS'($urandom()));
    r = r.first();
    do begin
      case (phase)
        1: value = reg_limit(r, 1'b0);
        2: value = reg_limit(r, 1'b1);
        3: value = (r == REG_RADIANCE_GAIN || r == REG_CONTOUR_DENSITY) ? '0 :
                   CFG_DATA_BITS'($urandom_range(511, UNIT_MAX + 1));
        4: value = '1;
        default: begin
          if ($urandom_range(3) == 0)
            value = CFG_DATA_BITS'($urandom());
          else
            value = CFG_DATA_BITS'($urandom_range(reg_limit(r, 1'b1), reg_limit(r, 1'b0)));
        end
      endcase
      cfg_write(r, value);
      r = r.next();
    end while (r != r.first());
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase;
    rst_n                  <= 1'b0;
    in_bus.valid           <= 1'b0;
    in_bus.corner_here     <= '0;
    in_bus.corner_right    <= '0;
    in_bus.corner_below    <= '0;
    in_bus.corner_diagonal <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= '0;
    cfg_bus.data           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cells[i]) send_cell(directed_cells[i]);
    wait_drained();

    // Each phase takes new settings while the block is empty, then streams
    // random cells under one of four idling patterns: none, a mostly idle
    // sender, a mostly stalled receiver, and light idling on both sides.
    for (phase = 1; phase <= PHASES; phase++) begin
      load_settings(phase);
      case ((phase - 1) % 4)
        0: begin src_idle_pct = 0;          snk_stall_pct <= 0;          end
        1: begin src_idle_pct = IDLE_HEAVY; snk_stall_pct <= 0;          end
        2: begin src_idle_pct = 0;          snk_stall_pct <= IDLE_HEAVY; end
        default: begin
          src_idle_pct  = IDLE_LIGHT;
          snk_stall_pct <= IDLE_LIGHT;
        end
      endcase
      repeat (CELLS_PER_PHASE) send_cell(random_cell());
      wait_drained();
    end

    if (fail_count == 0 && colours_pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // A run that hangs, for instance on a lost colour word, ends here.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
design/sfcc_pkg.sv
design/sfcc_if.sv
design/sfcc_geom.sv
design/sfcc_contour.sv
design/sfcc_colour.sv
design/scalar_field_contour_colormap.sv
bench/sfcc_checker.sv
bench/scalar_field_contour_colormap_tb.sv
